@@ sv/pti_pkg.sv @@
// Package: shared constants, tables and types of the planar twist integrator.
`timescale 1ns / 1ps

package pti_pkg;

    localparam int ATAN_ENTRIES = 20;
    localparam int CW           = 32;     // CORDIC x/y width, Q30
    localparam int ZW           = 34;     // CORDIC angle width, Q30
    localparam int SER_STEPS    = 4;
    localparam int SER_LAT      = 1 + 3 * SER_STEPS;
    localparam int MIX_LAT      = 4;
    localparam int RCP_SHIFT    = 32;

    localparam logic signed [CW-1:0] KC_Q30      = 32'sd652032874;
    localparam logic signed [ZW-1:0] HALF_PI_Q30 = 34'sd1686629713;
    localparam logic [28:0]          ONE_Q28     = 29'd268435456;

    // reciprocals for the constant divides of the series
    localparam logic [29:0] RCP_72 = 30'((64'd1 << RCP_SHIFT) / 72);
    localparam logic [29:0] RCP_42 = 30'((64'd1 << RCP_SHIFT) / 42);
    localparam logic [29:0] RCP_20 = 30'((64'd1 << RCP_SHIFT) / 20);
    localparam logic [29:0] RCP_6  = 30'((64'd1 << RCP_SHIFT) / 6);

    typedef struct packed {
        logic signed [15:0] lin_x;
        logic signed [15:0] lin_y;
        logic               zero_turn;
    } pti_side_t;

    typedef struct packed {
        logic signed [15:0] cos_out;
        logic signed [15:0] sin_out;
        logic signed [17:0] pos_x;
        logic signed [17:0] pos_y;
    } pti_result_t;

    function automatic logic signed [ZW-1:0] atan_q30(input int i);
        logic signed [ZW-1:0] a;
        unique case (i)
            0:       a = 34'sd843314857;
            1:       a = 34'sd497837830;
            2:       a = 34'sd263043837;
            3:       a = 34'sd133525159;
            4:       a = 34'sd67021687;
            5:       a = 34'sd33543516;
            6:       a = 34'sd16775851;
            7:       a = 34'sd8388437;
            8:       a = 34'sd4194283;
            9:       a = 34'sd2097149;
            10:      a = 34'sd1048576;
            11:      a = 34'sd524288;
            12:      a = 34'sd262144;
            13:      a = 34'sd131072;
            14:      a = 34'sd65536;
            15:      a = 34'sd32768;
            16:      a = 34'sd16384;
            17:      a = 34'sd8192;
            18:      a = 34'sd4096;
            19:      a = 34'sd2048;
            default: a = '0;
        endcase
        return a;
    endfunction

    function automatic logic [6:0] ser_div(input int j);
        logic [6:0] d;
        unique case (j)
            0:       d = 7'd72;
            1:       d = 7'd42;
            2:       d = 7'd20;
            default: d = 7'd6;
        endcase
        return d;
    endfunction

    function automatic logic [29:0] ser_rcp(input int j);
        logic [29:0] r;
        unique case (j)
            0:       r = RCP_72;
            1:       r = RCP_42;
            2:       r = RCP_20;
            default: r = RCP_6;
        endcase
        return r;
    endfunction

endpackage

@@ sv/pti_cordic.sv @@
// Pipelined rotation-mode CORDIC giving cos and sin of the half angle.
`timescale 1ns / 1ps

module pti_cordic import pti_pkg::*; #(
    parameter int NS  = 14,
    parameter int LAT = 15
) (
    input  logic                 aclk,
    input  logic                 en,
    input  logic signed [15:0]   turn,
    input  pti_side_t            side_in,
    output logic signed [CW-1:0] ch,
    output logic signed [CW-1:0] sh,
    output pti_side_t            side_out
);

    localparam int PAD = LAT - (NS + 1);
    localparam int PW  = 2 * CW + $bits(pti_side_t);

    logic signed [CW-1:0] x_reg [0:NS];
    logic signed [CW-1:0] y_reg [0:NS];
    logic signed [ZW-1:0] z_reg [0:NS];
    pti_side_t            side_reg [0:NS];
    logic signed [ZW-1:0] z_in;

    // turn is Q3.13 rad, i.e. the half angle in Q1.14; to Q30
    assign z_in = ZW'(turn) <<< 16;

    // quadrant pre-rotation keeps the iteration in range
    always_ff @(posedge aclk) begin
        if (en) begin
            side_reg[0] <= side_in;
            if (z_in > HALF_PI_Q30) begin
                x_reg[0] <= '0;
                y_reg[0] <= KC_Q30;
                z_reg[0] <= z_in - HALF_PI_Q30;
            end else if (z_in < -HALF_PI_Q30) begin
                x_reg[0] <= '0;
                y_reg[0] <= -KC_Q30;
                z_reg[0] <= z_in + HALF_PI_Q30;
            end else begin
                x_reg[0] <= KC_Q30;
                y_reg[0] <= '0;
                z_reg[0] <= z_in;
            end
        end
    end

    for (genvar i = 0; i < NS; i++) begin : g_stage
        logic signed [CW-1:0] dx;
        logic signed [CW-1:0] dy;
        assign dx = y_reg[i] >>> i;
        assign dy = x_reg[i] >>> i;
        always_ff @(posedge aclk) begin
            if (en) begin
                side_reg[i+1] <= side_reg[i];
                if (!z_reg[i][ZW-1]) begin
                    x_reg[i+1] <= x_reg[i] - dx;
                    y_reg[i+1] <= y_reg[i] + dy;
                    z_reg[i+1] <= z_reg[i] - atan_q30(i);
                end else begin
                    x_reg[i+1] <= x_reg[i] + dx;
                    y_reg[i+1] <= y_reg[i] - dy;
                    z_reg[i+1] <= z_reg[i] + atan_q30(i);
                end
            end
        end
    end

    // delay to the common core latency
    if (PAD > 0) begin : g_pad
        logic [PW-1:0] pad_reg [0:PAD-1];
        always_ff @(posedge aclk) begin
            if (en) begin
                pad_reg[0] <= {x_reg[NS], y_reg[NS], side_reg[NS]};
                for (int p = 1; p < PAD; p++) begin
                    pad_reg[p] <= pad_reg[p-1];
                end
            end
        end
        assign {ch, sh, side_out} = pad_reg[PAD-1];
    end else begin : g_nopad
        assign ch       = x_reg[NS];
        assign sh       = y_reg[NS];
        assign side_out = side_reg[NS];
    end

endmodule

@@ sv/pti_sinc.sv @@
// Pipelined series for k = sin(h)/h in Q28, one multiply or divide step per stage.
`timescale 1ns / 1ps

module pti_sinc import pti_pkg::*; #(
    parameter int LAT = 13
) (
    input  logic               aclk,
    input  logic               en,
    input  logic signed [15:0] turn,
    output logic [28:0]        k
);

    localparam int PAD = LAT - SER_LAT;

    logic [30:0] h2_reg [0:SER_STEPS];
    logic [28:0] t_reg  [0:SER_STEPS];
    logic signed [31:0] sq;

    assign sq = turn * turn;

    always_ff @(posedge aclk) begin
        if (en) begin
            h2_reg[0] <= sq[30:0];
            t_reg[0]  <= ONE_Q28;
        end
    end

    // step j: t = 1 - ((h2*t) >> 28) / D
    for (genvar j = 0; j < SER_STEPS; j++) begin : g_step
        logic [59:0] prod;
        logic [60:0] rprod;
        logic [30:0] m_reg;
        logic [30:0] mb_reg;
        logic [28:0] q0_reg;
        logic [30:0] ha_reg;
        logic [30:0] hb_reg;
        logic [31:0] rem;
        logic [28:0] q;

        assign prod  = h2_reg[j] * t_reg[j];
        assign rprod = m_reg * ser_rcp(j);
        assign rem   = 32'(mb_reg) - 32'(q0_reg) * 32'(ser_div(j));
        assign q     = q0_reg + 29'(rem >= 32'(ser_div(j)));

        always_ff @(posedge aclk) begin
            if (en) begin
                m_reg       <= prod[58:28];
                ha_reg      <= h2_reg[j];
                q0_reg      <= rprod[60:32];
                mb_reg      <= m_reg;
                hb_reg      <= ha_reg;
                t_reg[j+1]  <= ONE_Q28 - q;
                h2_reg[j+1] <= hb_reg;
            end
        end
    end

    if (PAD > 0) begin : g_pad
        logic [28:0] pad_reg [0:PAD-1];
        always_ff @(posedge aclk) begin
            if (en) begin
                pad_reg[0] <= t_reg[SER_STEPS];
                for (int p = 1; p < PAD; p++) begin
                    pad_reg[p] <= pad_reg[p-1];
                end
            end
        end
        assign k = pad_reg[PAD-1];
    end else begin : g_nopad
        assign k = t_reg[SER_STEPS];
    end

endmodule

@@ sv/pti_mix.sv @@
// Back end: double-angle cos/sin, rotated rates, scaling by k, rounding and clamps.
`timescale 1ns / 1ps

module pti_mix import pti_pkg::*; (
    input  logic                 aclk,
    input  logic                 en,
    input  logic signed [CW-1:0] ch,
    input  logic signed [CW-1:0] sh,
    input  logic [28:0]          k,
    input  pti_side_t            side_in,
    output pti_result_t          result
);

    // stage A: products
    logic signed [63:0] p_cc_reg, p_ss_reg, p_cs_reg;
    logic signed [47:0] p_cvx_reg, p_svy_reg, p_svx_reg, p_cvy_reg;
    logic [28:0]        k_a_reg;
    pti_side_t          side_a_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            p_cc_reg   <= 64'(ch) * 64'(ch);
            p_ss_reg   <= 64'(sh) * 64'(sh);
            p_cs_reg   <= 64'(ch) * 64'(sh);
            p_cvx_reg  <= 48'(ch) * 48'(side_in.lin_x);
            p_svy_reg  <= 48'(sh) * 48'(side_in.lin_y);
            p_svx_reg  <= 48'(sh) * 48'(side_in.lin_x);
            p_cvy_reg  <= 48'(ch) * 48'(side_in.lin_y);
            k_a_reg    <= k;
            side_a_reg <= side_in;
        end
    end

    // stage B: round cos/sin, rotated rates in Q8.16
    logic signed [63:0] cos_full, sin_full;
    logic signed [48:0] rx_sum, ry_sum;
    logic signed [15:0] cos_next, sin_next;
    logic signed [15:0] cos_b_reg, sin_b_reg;
    logic signed [26:0] rx_b_reg, ry_b_reg;
    logic [28:0]        k_b_reg;
    pti_side_t          side_b_reg;

    assign cos_full = (p_cc_reg - p_ss_reg + (64'sd1 <<< 45)) >>> 46;
    assign sin_full = (p_cs_reg + (64'sd1 <<< 44)) >>> 45;
    assign rx_sum   = 49'(p_cvx_reg) - 49'(p_svy_reg) + (49'sd1 <<< 21);
    assign ry_sum   = 49'(p_svx_reg) + 49'(p_cvy_reg) + (49'sd1 <<< 21);

    always_comb begin
        priority if (cos_full > 64'sd16384)  cos_next = 16'sd16384;
        else if (cos_full < -64'sd16384)     cos_next = -16'sd16384;
        else                                 cos_next = cos_full[15:0];
        priority if (sin_full > 64'sd16384)  sin_next = 16'sd16384;
        else if (sin_full < -64'sd16384)     sin_next = -16'sd16384;
        else                                 sin_next = sin_full[15:0];
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            cos_b_reg  <= cos_next;
            sin_b_reg  <= sin_next;
            rx_b_reg   <= rx_sum[48:22];
            ry_b_reg   <= ry_sum[48:22];
            k_b_reg    <= k_a_reg;
            side_b_reg <= side_a_reg;
        end
    end

    // stage C: scale by k
    logic signed [56:0] prx_reg, pry_reg;
    logic signed [15:0] cos_c_reg, sin_c_reg;
    pti_side_t          side_c_reg;
    logic signed [29:0] k_s;

    assign k_s = {1'b0, k_b_reg};

    always_ff @(posedge aclk) begin
        if (en) begin
            prx_reg    <= 57'(rx_b_reg) * 57'(k_s);
            pry_reg    <= 57'(ry_b_reg) * 57'(k_s);
            cos_c_reg  <= cos_b_reg;
            sin_c_reg  <= sin_b_reg;
            side_c_reg <= side_b_reg;
        end
    end

    // stage D: round, clamp, zero-turn bypass
    logic signed [56:0] px_full, py_full;
    logic signed [17:0] px_sat, py_sat;
    pti_result_t        result_next;
    pti_result_t        result_reg;

    assign px_full = (prx_reg + (57'sd1 <<< 35)) >>> 36;
    assign py_full = (pry_reg + (57'sd1 <<< 35)) >>> 36;

    always_comb begin
        priority if (px_full > 57'sd65536)   px_sat = 18'sd65536;
        else if (px_full < -57'sd65536)      px_sat = -18'sd65536;
        else                                 px_sat = px_full[17:0];
        priority if (py_full > 57'sd65536)   py_sat = 18'sd65536;
        else if (py_full < -57'sd65536)      py_sat = -18'sd65536;
        else                                 py_sat = py_full[17:0];

        if (side_c_reg.zero_turn) begin
            result_next.cos_out = 16'sd16384;
            result_next.sin_out = '0;
            result_next.pos_x   = 18'(side_c_reg.lin_x);
            result_next.pos_y   = 18'(side_c_reg.lin_y);
        end else begin
            result_next.cos_out = cos_c_reg;
            result_next.sin_out = sin_c_reg;
            result_next.pos_x   = px_sat;
            result_next.pos_y   = py_sat;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            result_reg <= result_next;
        end
    end

    assign result = result_reg;

endmodule

@@ sv/planar_twist_integrator_core.sv @@
// Top level: SE(2) exponential map of a planar twist, streaming in and out.
`timescale 1ns / 1ps

//  channel | dir | tdata fields (lsb first)                         | beat
//  s_      | in  | lin_x[15:0] lin_y[31:16] turn[47:32]             | one twist
//  m_      | out | cos_out[15:0] sin_out[31:16] pos_x[49:32]       | one transform
//          |     | pos_y[67:50], zero fill [71:68]                  |
//
//  One beat in and one beat out per cycle unless m_ stalls; latency is
//  set by the CORDIC chain (CORDIC_STAGES, capped at 20) or the
//  13-stage sinc series if longer, four back-end stages and the output
//  register. Reset clears the valid bits only. A stall at m_ parks one
//  beat in a skid register; the pipe freezes while it is full.

module planar_twist_integrator_core import pti_pkg::*; #(
    parameter int CORDIC_STAGES = 14
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [47:0] s_tdata,   // lin_x, lin_y, turn
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [71:0] m_tdata    // cos_out, sin_out, pos_x, pos_y, pad
);

    // stages past the table length are not performed
    localparam int NS       = (CORDIC_STAGES > ATAN_ENTRIES) ? ATAN_ENTRIES : CORDIC_STAGES;
    localparam int CORE_LAT = (NS + 1 > SER_LAT) ? NS + 1 : SER_LAT;
    localparam int TOT      = CORE_LAT + MIX_LAT;

    logic               en;
    logic signed [15:0] turn;
    pti_side_t          side_in, side_core;
    logic signed [CW-1:0] ch, sh;
    logic [28:0]        k;
    pti_result_t        tail;

    logic               v_reg [0:TOT-1];
    logic               out_valid_reg;
    pti_result_t        out_reg;
    logic               skid_valid_reg;
    pti_result_t        skid_reg;

    // the whole pipe advances unless the skid beat is waiting
    assign en       = !skid_valid_reg;
    assign s_tready = en;

    assign turn              = s_tdata[47:32];
    assign side_in.lin_x     = s_tdata[15:0];
    assign side_in.lin_y     = s_tdata[31:16];
    assign side_in.zero_turn = (turn == '0);

    pti_cordic #(.NS(NS), .LAT(CORE_LAT)) u_cordic (
        .aclk     (aclk),
        .en       (en),
        .turn     (turn),
        .side_in  (side_in),
        .ch       (ch),
        .sh       (sh),
        .side_out (side_core)
    );

    pti_sinc #(.LAT(CORE_LAT)) u_sinc (
        .aclk (aclk),
        .en   (en),
        .turn (turn),
        .k    (k)
    );

    pti_mix u_mix (
        .aclk    (aclk),
        .en      (en),
        .ch      (ch),
        .sh      (sh),
        .k       (k),
        .side_in (side_core),
        .result  (tail)
    );

    // valid bits ride alongside the data stages
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < TOT; i++) begin
                v_reg[i] <= 1'b0;
            end
        end else if (en) begin
            v_reg[0] <= s_tvalid;
            for (int i = 1; i < TOT; i++) begin
                v_reg[i] <= v_reg[i-1];
            end
        end
    end

    // output register plus skid
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (m_tready || !out_valid_reg) begin
            if (skid_valid_reg) begin
                out_valid_reg  <= 1'b1;
                skid_valid_reg <= 1'b0;
            end else begin
                out_valid_reg  <= v_reg[TOT-1];
            end
        end else if (v_reg[TOT-1] && !skid_valid_reg) begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (m_tready || !out_valid_reg) begin
            out_reg <= skid_valid_reg ? skid_reg : tail;
        end else if (!skid_valid_reg) begin
            skid_reg <= tail;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {4'b0, out_reg.pos_y, out_reg.pos_x, out_reg.sin_out, out_reg.cos_out};

`ifndef SYNTHESIS
    // the skid only holds a beat behind a waiting output beat
    a_skid_behind_out: assert property (@(posedge aclk) disable iff (!aresetn)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid full while output empty");

    a_skid_fill: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(skid_valid_reg) |-> $past(out_valid_reg && !m_tready))
        else $error("skid filled without output stall");

    a_cos_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> ($signed(m_tdata[15:0]) <= 16'sd16384) &&
                     ($signed(m_tdata[15:0]) >= -16'sd16384))
        else $error("cos_out out of range");
`endif

endmodule
